// ===== hw/rtl/hard_sphere_collision_velocity_defines.svh =====
// Assertion macros for the collision block checker.
`ifndef HARD_SPHERE_COLLISION_VELOCITY_DEFINES_SVH
`define HARD_SPHERE_COLLISION_VELOCITY_DEFINES_SVH

// Plain property on clk, off while rst_n is low.
`define HSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication on clk, off while rst_n is low.
`define HSC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/hsc_pkg.sv =====
// Types, constants and tables for the hard-sphere collision pipeline.
`timescale 1ns / 1ps

package hsc_pkg;

    // Input word: two velocities, relative speed and two random fractions
    typedef struct packed {
        logic signed [31:0] first_vx;
        logic signed [31:0] first_vy;
        logic signed [31:0] first_vz;
        logic signed [31:0] second_vx;
        logic signed [31:0] second_vy;
        logic signed [31:0] second_vz;
        logic [30:0]        rel_speed;
        logic [15:0]        uniform_theta;
        logic [15:0]        uniform_phi;
    } hsc_in_t;

    // Result word: post-collision velocities
    typedef struct packed {
        logic signed [31:0] new_first_vx;
        logic signed [31:0] new_first_vy;
        logic signed [31:0] new_first_vz;
        logic signed [31:0] new_second_vx;
        logic signed [31:0] new_second_vy;
        logic signed [31:0] new_second_vz;
    } hsc_out_t;

    // Values that ride alongside the sqrt and CORDIC pipes
    typedef struct packed {
        logic signed [32:0] sum_x;
        logic signed [32:0] sum_y;
        logic signed [32:0] sum_z;
        logic [30:0]        rel_speed;
        logic signed [17:0] cos_th;
        logic               flip;
    } hsc_side_t;

    localparam int ATAN_ENTRIES = 24;
    localparam int SQRT_STEPS   = 17;
    // Front register plus the three product/sum stages after the angle pipes
    localparam int PIPE_EXTRA   = 4;

    localparam logic signed [33:0] GAIN_Q30   = 34'sd652032874;
    localparam logic signed [33:0] TWO_PI_Q30 = 34'sd6746518852;

    // atan(2^-i) in Q30
    function automatic logic signed [33:0] atan_q30(input int idx);
        logic signed [33:0] val;
        case (idx)
            0:       val = 34'sd843314857;
            1:       val = 34'sd497837829;
            2:       val = 34'sd263043837;
            3:       val = 34'sd133525159;
            4:       val = 34'sd67021687;
            5:       val = 34'sd33543516;
            6:       val = 34'sd16775851;
            7:       val = 34'sd8388437;
            8:       val = 34'sd4194283;
            9:       val = 34'sd2097149;
            10:      val = 34'sd1048576;
            11:      val = 34'sd524288;
            12:      val = 34'sd262144;
            13:      val = 34'sd131072;
            14:      val = 34'sd65536;
            15:      val = 34'sd32768;
            16:      val = 34'sd16384;
            17:      val = 34'sd8192;
            18:      val = 34'sd4096;
            19:      val = 34'sd2048;
            20:      val = 34'sd1024;
            21:      val = 34'sd512;
            22:      val = 34'sd256;
            23:      val = 34'sd128;
            default: val = 34'sd0;
        endcase
        return val;
    endfunction

endpackage

// ===== hw/rtl/hsc_delay.sv =====
// Fixed-length register delay line for payload that waits on a longer pipe.
`timescale 1ns / 1ps

module hsc_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    generate
        if (DEPTH == 0) begin : g_none
            assign dout = din;
        end
        else begin : g_line
            logic [WIDTH-1:0] tap_reg [DEPTH];

            // Advance every tap each cycle
            always_ff @(posedge clk)
            begin
                tap_reg[0] <= din;
                for (int i = 1; i < DEPTH; i++)
                begin
                    tap_reg[i] <= tap_reg[i-1];
                end
            end

            assign dout = tap_reg[DEPTH-1];
        end
    endgenerate

endmodule

// ===== hw/rtl/hsc_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module hsc_sqrt
    import hsc_pkg::*;
(
    input  logic        clk,
    input  logic [32:0] radicand,
    output logic [16:0] root
);

    logic [33:0] rem_reg [SQRT_STEPS+1];
    logic [33:0] res_reg [SQRT_STEPS+1];

    assign rem_reg[0] = {1'b0, radicand};
    assign res_reg[0] = '0;

    generate
        for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_stage
            localparam logic [33:0] BIT_VAL = 34'd1 << (2 * (SQRT_STEPS - 1 - i));
            logic [33:0] trial;
            logic [33:0] rem_next;
            logic [33:0] res_next;

            // Try to take off the next bit
            always_comb
            begin
                trial = res_reg[i] + BIT_VAL;
                if (rem_reg[i] >= trial)
                begin
                    rem_next = rem_reg[i] - trial;
                    res_next = (res_reg[i] >> 1) + BIT_VAL;
                end
                else
                begin
                    rem_next = rem_reg[i];
                    res_next = res_reg[i] >> 1;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[i+1] <= rem_next;
                res_reg[i+1] <= res_next;
            end
        end
    endgenerate

    assign root = res_reg[SQRT_STEPS][16:0];

endmodule

// ===== hw/rtl/hsc_cordic.sv =====
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
`timescale 1ns / 1ps

module hsc_cordic
    import hsc_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  logic               clk,
    input  logic signed [33:0] angle,
    output logic signed [33:0] cos_out,
    output logic signed [33:0] sin_out
);

    logic signed [33:0] x_reg [STEPS+1];
    logic signed [33:0] y_reg [STEPS+1];
    logic signed [33:0] z_reg [STEPS+1];

    assign x_reg[0] = GAIN_Q30;
    assign y_reg[0] = '0;
    assign z_reg[0] = angle;

    generate
        for (genvar i = 0; i < STEPS; i++) begin : g_stage
            localparam logic signed [33:0] ATAN_I = atan_q30(i);
            logic signed [33:0] x_next;
            logic signed [33:0] y_next;
            logic signed [33:0] z_next;

            // Rotate toward zero residual angle
            always_comb
            begin
                if (!z_reg[i][33])
                begin
                    x_next = x_reg[i] - (y_reg[i] >>> i);
                    y_next = y_reg[i] + (x_reg[i] >>> i);
                    z_next = z_reg[i] - ATAN_I;
                end
                else
                begin
                    x_next = x_reg[i] + (y_reg[i] >>> i);
                    y_next = y_reg[i] - (x_reg[i] >>> i);
                    z_next = z_reg[i] + ATAN_I;
                end
            end

            always_ff @(posedge clk)
            begin
                x_reg[i+1] <= x_next;
                y_reg[i+1] <= y_next;
                z_reg[i+1] <= z_next;
            end
        end
    endgenerate

    assign cos_out = x_reg[STEPS];
    assign sin_out = y_reg[STEPS];

endmodule

// ===== hw/rtl/hard_sphere_collision_velocity.sv =====
// Top level: isotropic hard-sphere collision velocity pipeline.
//
//   channel   ports                         timing
//   input     start, busy, operands         taken when start && !busy
//   result    result_valid, result          one-cycle strobe, no backpressure
//
// One collision pair enters every cycle; busy is always low.
// The 17-stage square root or the CORDIC pipe, whichever is the longer,
// sets the depth, plus a front register and three multiply/sum stages.
// Reset clears only the valid bits; data in flight is dropped. Nothing
// ever stalls.
`timescale 1ns / 1ps

module hard_sphere_collision_velocity
    import hsc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  hsc_in_t  operands,
    output logic     result_valid,
    output hsc_out_t result
);

    localparam int CORDIC_N = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int ANGLE_LAT = (CORDIC_N > SQRT_STEPS) ? CORDIC_N : SQRT_STEPS;
    localparam int LAT = ANGLE_LAT + PIPE_EXTRA;

    // Valid bits
    logic [LAT-1:0] valid_reg;
    logic [LAT-1:0] valid_next;

    assign busy = 1'b0;
    assign valid_next = {valid_reg[LAT-2:0], start && !busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg[LAT-1];

    // Front stage: cos(theta), sqrt radicand, folded phi angle, sums
    logic [16:0]        theta_rest;
    logic [32:0]        theta_prod;
    logic               flip;
    logic signed [15:0] turn;
    logic signed [49:0] angle_prod;
    hsc_side_t          side_next;
    hsc_side_t          side_reg;
    logic [32:0]        rad_reg;
    logic signed [33:0] angle_reg;

    always_comb
    begin
        theta_rest = 17'd65536 - {1'b0, operands.uniform_theta};
        theta_prod = 33'(operands.uniform_theta * theta_rest);
        flip = operands.uniform_phi[15] ^ operands.uniform_phi[14];
        turn = flip ? $signed({~operands.uniform_phi[15], operands.uniform_phi[14:0]})
                    : $signed(operands.uniform_phi);
        angle_prod = 50'(turn) * 50'(TWO_PI_Q30);
        side_next.sum_x = 33'(operands.first_vx) + 33'(operands.second_vx);
        side_next.sum_y = 33'(operands.first_vy) + 33'(operands.second_vy);
        side_next.sum_z = 33'(operands.first_vz) + 33'(operands.second_vz);
        side_next.rel_speed = operands.rel_speed;
        side_next.cos_th = $signed(18'd65536 - {1'b0, operands.uniform_theta, 1'b0});
        side_next.flip = flip;
    end

    always_ff @(posedge clk)
    begin
        side_reg  <= side_next;
        rad_reg   <= {theta_prod[30:0], 2'b00};
        angle_reg <= angle_prod[49:16];
    end

    // Angle pipes, aligned to the longer one
    logic [16:0]        sin_th_raw;
    logic [16:0]        sin_th;
    logic signed [33:0] cphi_raw;
    logic signed [33:0] sphi_raw;
    logic [67:0]        phi_d;
    hsc_side_t          side_d;

    hsc_sqrt u_sqrt (
        .clk      (clk),
        .radicand (rad_reg),
        .root     (sin_th_raw)
    );

    hsc_cordic #(
        .STEPS (CORDIC_N)
    ) u_cordic (
        .clk     (clk),
        .angle   (angle_reg),
        .cos_out (cphi_raw),
        .sin_out (sphi_raw)
    );

    hsc_delay #(
        .WIDTH (17),
        .DEPTH (ANGLE_LAT - SQRT_STEPS)
    ) u_sqrt_dly (
        .clk  (clk),
        .din  (sin_th_raw),
        .dout (sin_th)
    );

    hsc_delay #(
        .WIDTH (68),
        .DEPTH (ANGLE_LAT - CORDIC_N)
    ) u_cordic_dly (
        .clk  (clk),
        .din  ({cphi_raw, sphi_raw}),
        .dout (phi_d)
    );

    hsc_delay #(
        .WIDTH ($bits(hsc_side_t)),
        .DEPTH (ANGLE_LAT)
    ) u_side_dly (
        .clk  (clk),
        .din  (side_reg),
        .dout (side_d)
    );

    // Stage A: scale by speed, apply the half-turn flip
    logic signed [48:0] vx_prod;
    logic [47:0]        span_prod;
    logic signed [32:0] a_vx_reg;
    logic [30:0]        a_span_reg;
    logic signed [33:0] a_cphi_reg;
    logic signed [33:0] a_sphi_reg;
    logic signed [32:0] a_sum_reg [3];

    assign vx_prod   = $signed({18'd0, side_d.rel_speed}) * 49'(side_d.cos_th);
    assign span_prod = {17'd0, side_d.rel_speed} * {31'd0, sin_th};

    always_ff @(posedge clk)
    begin
        a_vx_reg   <= vx_prod[48:16];
        a_span_reg <= span_prod[46:16];
        a_cphi_reg <= side_d.flip ? -$signed(phi_d[67:34]) : $signed(phi_d[67:34]);
        a_sphi_reg <= side_d.flip ? -$signed(phi_d[33:0]) : $signed(phi_d[33:0]);
        a_sum_reg[0] <= side_d.sum_x;
        a_sum_reg[1] <= side_d.sum_y;
        a_sum_reg[2] <= side_d.sum_z;
    end

    // Stage B: project span onto phi
    logic signed [65:0] vy_prod;
    logic signed [65:0] vz_prod;
    logic signed [32:0] b_vrel_reg [3];
    logic signed [32:0] b_sum_reg [3];

    assign vy_prod = $signed({35'd0, a_span_reg}) * 66'(a_cphi_reg);
    assign vz_prod = $signed({35'd0, a_span_reg}) * 66'(a_sphi_reg);

    always_ff @(posedge clk)
    begin
        b_vrel_reg[0] <= a_vx_reg;
        b_vrel_reg[1] <= vy_prod[62:30];
        b_vrel_reg[2] <= vz_prod[62:30];
        b_sum_reg     <= a_sum_reg;
    end

    // Output stage: halve sum plus/minus relative velocity, saturate
    function automatic logic signed [31:0] sat_half(input logic signed [34:0] v);
        logic signed [33:0] h;
        h = v[34:1];
        if (h > 34'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (h < -34'sd2147483648)
            return 32'h8000_0000;
        else
            return h[31:0];
    endfunction

    logic signed [31:0] plus_val  [3];
    logic signed [31:0] minus_val [3];
    hsc_out_t           result_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            plus_val[k]  = sat_half(35'(b_sum_reg[k]) + 35'(b_vrel_reg[k]));
            minus_val[k] = sat_half(35'(b_sum_reg[k]) - 35'(b_vrel_reg[k]));
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.new_first_vx  <= plus_val[0];
        result_reg.new_first_vy  <= plus_val[1];
        result_reg.new_first_vz  <= plus_val[2];
        result_reg.new_second_vx <= minus_val[0];
        result_reg.new_second_vy <= minus_val[1];
        result_reg.new_second_vz <= minus_val[2];
    end

    assign result = result_reg;

endmodule

// ===== hw/rtl/hsc_checker.sv =====
// Port-level checker for the collision pipeline, bound to the top level.
`timescale 1ns / 1ps
`include "hard_sphere_collision_velocity_defines.svh"

module hsc_checker
    import hsc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input hsc_in_t  operands,
    input logic     result_valid,
    input hsc_out_t result
);

    localparam int CORDIC_N = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int ANGLE_LAT = (CORDIC_N > SQRT_STEPS) ? CORDIC_N : SQRT_STEPS;
    localparam int LAT = ANGLE_LAT + PIPE_EXTRA;

    // Accepted words, and those that lie on the polar axis
    logic accept;
    logic axis_word;
    logic cross_eq;

    assign accept    = start && !busy;
    assign axis_word = accept && (operands.uniform_theta == 16'd0);
    assign cross_eq  = (result.new_first_vy == result.new_second_vy)
                    && (result.new_first_vz == result.new_second_vz);

    `HSC_ASSERT(a_never_busy, !busy, "busy raised on a non-stalling pipe")

    `HSC_ASSERT_IMPL(a_word_out, $past(accept, LAT), result_valid, "accepted word lost")

    `HSC_ASSERT_IMPL(a_word_in, result_valid, $past(accept, LAT), "result without a word")

    `HSC_ASSERT_IMPL(a_polar_axis, $past(axis_word, LAT), cross_eq, "off-axis terms")

endmodule

bind hard_sphere_collision_velocity hsc_checker #(
    .CORDIC_STEPS (CORDIC_STEPS)
) u_hsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .operands     (operands),
    .result_valid (result_valid),
    .result       (result)
);

// ===== test/tb.sv =====
// Self-checking bench for the hard-sphere collision velocity pipeline.
`timescale 1ns / 1ps

module tb;
    import hsc_pkg::*;

    localparam int STEPS     = 16;
    localparam int LATENCY   = 21;
    localparam int N_RANDOM  = 450;
    localparam int MAX_CYCLE = 200000;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    // Compute post-collision velocities for one input word
    function automatic hsc_out_t collide(hsc_in_t w);
        longint cr, cth, sth, r, z, x, y, dx, dy, cph, sph, span, n;
        longint rem, res, bitv;
        longint sum [3];
        longint vrel [3];
        longint v;
        bit flip;
        hsc_out_t o;
        logic signed [31:0] outv [6];
        cr = longint'(w.rel_speed);
        cth = 65536 - 2 * longint'(w.uniform_theta);
        // integer square root of 2^32 - cos^2
        n = 64'sd4294967296 - cth * cth;
        res = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > n) bitv = bitv >>> 2;
        rem = n;
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >>> 1) + bitv;
            end
            else
                res = res >>> 1;
            bitv = bitv >>> 2;
        end
        sth = res;
        // fold azimuth into a quarter turn either side of zero
        r = longint'(w.uniform_phi);
        flip = 0;
        if (r >= 16384 && r < 49152)
        begin
            r = r - 32768;
            flip = 1;
        end
        else if (r >= 49152)
            r = r - 65536;
        z = (r * longint'(TWO_PI_Q30)) >>> 16;
        x = longint'(GAIN_Q30);
        y = 0;
        for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_q30(i));
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_q30(i));
            end
        end
        cph = flip ? -x : x;
        sph = flip ? -y : y;
        sum[0] = longint'(w.first_vx) + longint'(w.second_vx);
        sum[1] = longint'(w.first_vy) + longint'(w.second_vy);
        sum[2] = longint'(w.first_vz) + longint'(w.second_vz);
        vrel[0] = (cr * cth) >>> 16;
        span = (cr * sth) >>> 16;
        vrel[1] = (span * cph) >>> 30;
        vrel[2] = (span * sph) >>> 30;
        // halve and saturate each component
        for (int k = 0; k < 3; k++)
        begin
            v = (sum[k] + vrel[k]) >>> 1;
            outv[k] = (v > SAT_HI) ? 32'sh7fffffff :
                      (v < SAT_LO) ? 32'sh80000000 : v[31:0];
            v = (sum[k] - vrel[k]) >>> 1;
            outv[k + 3] = (v > SAT_HI) ? 32'sh7fffffff :
                          (v < SAT_LO) ? 32'sh80000000 : v[31:0];
        end
        o.new_first_vx = outv[0];
        o.new_first_vy = outv[1];
        o.new_first_vz = outv[2];
        o.new_second_vx = outv[3];
        o.new_second_vy = outv[4];
        o.new_second_vz = outv[5];
        return o;
    endfunction

    // Hold expected velocity words in arrival order
    class velocity_board;
        hsc_out_t pending [$];
        int errors;

        function void note_word(hsc_in_t w);
            pending.push_back(collide(w));
        endfunction

        function void check_word(hsc_out_t got);
            hsc_out_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.new_first_vx !== want.new_first_vx)
                $display("%0t: new_first_vx exp %h got %h", $time,
                         want.new_first_vx, got.new_first_vx);
            if (got.new_first_vy !== want.new_first_vy)
                $display("%0t: new_first_vy exp %h got %h", $time,
                         want.new_first_vy, got.new_first_vy);
            if (got.new_first_vz !== want.new_first_vz)
                $display("%0t: new_first_vz exp %h got %h", $time,
                         want.new_first_vz, got.new_first_vz);
            if (got.new_second_vx !== want.new_second_vx)
                $display("%0t: new_second_vx exp %h got %h", $time,
                         want.new_second_vx, got.new_second_vx);
            if (got.new_second_vy !== want.new_second_vy)
                $display("%0t: new_second_vy exp %h got %h", $time,
                         want.new_second_vy, got.new_second_vy);
            if (got.new_second_vz !== want.new_second_vz)
                $display("%0t: new_second_vz exp %h got %h", $time,
                         want.new_second_vz, got.new_second_vz);
            if (got !== want)
                errors++;
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    hsc_in_t operands = '0;
    logic result_valid;
    hsc_out_t result;
    velocity_board board = new();
    int cycle = 0;
    bit quiet = 0;

    hard_sphere_collision_velocity #(.CORDIC_STEPS(STEPS)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operands(operands), .result_valid(result_valid), .result(result)
    );

    always #6 clk = ~clk;

    // Note accepted words, check results, watch the cycle limit
    always @(posedge clk)
    begin
        cycle++;
        if (rst_n && start && !busy)
            board.note_word(operands);
        if (rst_n && result_valid)
            board.check_word(result);
        if (cycle > MAX_CYCLE)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] edge_val(int sel);
        case (sel)
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'hffffffff;
            default: return $urandom();
        endcase
    endfunction

    // Drive one word, with an optional random gap before it
    task automatic send_word(hsc_in_t w);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            start <= 0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        start <= 1;
        operands <= w;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    hsc_in_t w;
    initial
    begin
        repeat (3) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        // Field extremes, saturation and angle fold boundaries
        for (int d = 0; d < 24; d++)
        begin
            w.first_vx = edge_val(d % 4);
            w.first_vy = edge_val((d / 2) % 4);
            w.first_vz = edge_val((d + 1) % 4);
            w.second_vx = edge_val(d % 4);
            w.second_vy = edge_val((d / 3) % 4);
            w.second_vz = edge_val((d + 3) % 4);
            w.rel_speed = (d % 3 == 0) ? 31'h7fffffff : (d % 3 == 1) ? 31'd0 :
                          31'($urandom());
            case (d % 8)
                0: w.uniform_phi = 16'd0;
                1: w.uniform_phi = 16'd16383;
                2: w.uniform_phi = 16'd16384;
                3: w.uniform_phi = 16'd32768;
                4: w.uniform_phi = 16'd49151;
                5: w.uniform_phi = 16'd49152;
                6: w.uniform_phi = 16'hffff;
                default: w.uniform_phi = 16'($urandom());
            endcase
            w.uniform_theta = (d % 5 == 0) ? 16'd0 : (d % 5 == 1) ? 16'hffff :
                              (d % 5 == 2) ? 16'd32768 : 16'($urandom());
            send_word(w);
        end
        // Pause until the pipe is empty
        drain();
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i > N_RANDOM - 80)
                quiet = 1;
            w.first_vx = $urandom();
            w.first_vy = $urandom();
            w.first_vz = $urandom();
            w.second_vx = $urandom();
            w.second_vy = $urandom();
            w.second_vz = $urandom();
            w.rel_speed = 31'($urandom());
            w.uniform_theta = 16'($urandom());
            w.uniform_phi = 16'($urandom());
            if ($urandom_range(0, 1))
            begin
                // realistic speeds make saturation of the results rare
                w.first_vx = $signed(w.first_vx) >>> 8;
                w.second_vy = $signed(w.second_vy) >>> 8;
                w.rel_speed = w.rel_speed >> 8;
            end
            send_word(w);
        end
        drain();
        if (board.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
